// File: design/cpc_pkg.sv
// Shared types and constants of the cartesian-to-polar classifier
`timescale 1ns / 1ps
package cpc_pkg;

   // Angle accumulator: signed radians with 30 fraction bits
   localparam int ANGLE_WIDTH = 34;

   localparam logic signed [ANGLE_WIDTH-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;

   // CORDIC gain limit in Q0.32 and degrees per radian in Q24
   localparam logic [31:0] GAIN_Q32        = 32'd2608131496;
   localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

   // Clamp limits of the quadrant angles
   localparam logic signed [17:0] RAD_MAX = 18'sd25736;
   localparam logic signed [17:0] RAD_MIN = -18'sd25735;
   localparam logic signed [17:0] DEG_MAX = 18'sd23040;
   localparam logic signed [17:0] DEG_MIN = -18'sd23039;

   // Side information that travels with each word down the chain
   typedef struct packed {
      logic [3:0] location;
      logic       axis;
   } cpc_meta_type;

   // Arctangent of 2^-idx for idx 0 to 23, truncated to 2^-30; zero beyond
   function automatic logic [ANGLE_WIDTH-1:0] atan_q30(input int unsigned idx);
      logic [ANGLE_WIDTH-1:0] val;
      case (idx)
         0:  val = 34'h03243F6A8;
         1:  val = 34'h01DAC6705;
         2:  val = 34'h00FADBAFC;
         3:  val = 34'h007F56EA6;
         4:  val = 34'h003FEAB76;
         5:  val = 34'h001FFD55B;
         6:  val = 34'h000FFFAAA;
         7:  val = 34'h0007FFF55;
         8:  val = 34'h0003FFFEA;
         9:  val = 34'h0001FFFFD;
         10: val = 34'h0000FFFFF;
         11: val = 34'h00007FFFF;
         12: val = 34'h00003FFFF;
         13: val = 34'h00001FFFF;
         14: val = 34'h00000FFFF;
         15: val = 34'h000007FFF;
         16: val = 34'h000003FFF;
         17: val = 34'h000001FFF;
         18: val = 34'h000000FFF;
         19: val = 34'h0000007FF;
         20: val = 34'h0000003FF;
         21: val = 34'h0000001FF;
         22: val = 34'h0000000FF;
         23: val = 34'h00000007F;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: design/cpc_cordic_cell.sv
// One CORDIC vectoring cell: a micro-rotation by atan(2^-SHIFT), registered
`timescale 1ns / 1ps
module cpc_cordic_cell #(
   parameter int XY_WIDTH = 35,
   parameter int SHIFT    = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 valid_i,
   input  cpc_pkg::cpc_meta_type                meta_i,
   input  logic signed [XY_WIDTH-1:0]           cx_i,
   input  logic signed [XY_WIDTH-1:0]           cy_i,
   input  logic signed [cpc_pkg::ANGLE_WIDTH-1:0] z_i,
   output logic                                 valid_o,
   output cpc_pkg::cpc_meta_type                meta_o,
   output logic signed [XY_WIDTH-1:0]           cx_o,
   output logic signed [XY_WIDTH-1:0]           cy_o,
   output logic signed [cpc_pkg::ANGLE_WIDTH-1:0] z_o
);
   import cpc_pkg::*;

   localparam logic signed [ANGLE_WIDTH-1:0] ATAN = atan_q30(SHIFT);

   logic                          valid_ff;
   cpc_meta_type                  meta_ff;
   logic signed [XY_WIDTH-1:0]    cx_ff, cx_in;
   logic signed [XY_WIDTH-1:0]    cy_ff, cy_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;

   // Rotate toward the x axis; hold axis words unchanged
   always_comb begin
      cx_in = cx_i;
      cy_in = cy_i;
      z_in  = z_i;
      if (!meta_i.axis) begin
         if (!cy_i[XY_WIDTH-1]) begin
            cx_in = cx_i + (cy_i >>> SHIFT);
            cy_in = cy_i - (cx_i >>> SHIFT);
            z_in  = z_i + ATAN;
         end else begin
            cx_in = cx_i - (cy_i >>> SHIFT);
            cy_in = cy_i + (cx_i >>> SHIFT);
            z_in  = z_i - ATAN;
         end
      end
   end

   // Advance the word to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      meta_ff <= meta_i;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
   end

   assign valid_o = valid_ff;
   assign meta_o  = meta_ff;
   assign cx_o    = cx_ff;
   assign cy_o    = cy_ff;
   assign z_o     = z_ff;

endmodule

// File: design/cpc_post.sv
// Gain correction, rounding and clamping after the CORDIC chain
`timescale 1ns / 1ps
module cpc_post #(
   parameter int XY_WIDTH = 35
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   valid_i,
   input  cpc_pkg::cpc_meta_type                  meta_i,
   input  logic signed [XY_WIDTH-1:0]             cx_i,
   input  logic signed [cpc_pkg::ANGLE_WIDTH-1:0] z_i,
   output logic                                   rsp_valid,
   output logic [15:0]                            rsp_radius,
   output logic signed [15:0]                     rsp_angle_rad,
   output logic signed [15:0]                     rsp_angle_deg,
   output logic [3:0]                             rsp_location
);
   import cpc_pkg::*;

   // Multiply stage one
   logic                valid1_ff;
   cpc_meta_type        meta1_ff;
   logic [63:0]         t1_ff;
   logic [31:0]         hi1_ff;
   logic [32:0]         av1_ff;
   logic                zneg1_ff;
   logic [15:0]         arad1_ff;
   logic [63:0]         ux;
   logic [ANGLE_WIDTH-1:0] zabs;
   logic [15:0]         arad_in;

   // Multiply stage two
   logic                valid2_ff;
   cpc_meta_type        meta2_ff;
   logic [63:0]         h2_ff;
   logic [31:0]         thi2_ff;
   logic [62:0]         p2_ff;
   logic [16:0]         rmag2_ff;
   logic                zneg2_ff;
   logic [15:0]         arad2_ff;
   logic [33:0]         rsum;

   // Output stage
   logic                valid3_ff;
   logic [15:0]         radius_ff, radius_in;
   logic signed [15:0]  rad_ff;
   logic signed [15:0]  deg_ff;
   logic [3:0]          loc_ff;
   logic [63:0]         ssum;
   logic [63:0]         psum;
   logic signed [17:0]  rad_s, deg_s, rad_c, deg_c;

   // Clip negative magnitude, take |z|, saturate the exact axis radius
   always_comb begin
      ux   = cx_i[XY_WIDTH-1] ? 64'd0 : {{(64-XY_WIDTH){1'b0}}, cx_i};
      zabs = z_i[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(-z_i) : z_i;
      arad_in = (|ux[63:16]) ? 16'hFFFF : ux[15:0];
   end

   assign rsum = {1'b0, av1_ff} + 34'h10000;

   // Sum the gain partial products, saturate the radius, round and clamp the angles
   always_comb begin
      ssum = {32'd0, thi2_ff} + h2_ff + 64'h8000;
      psum = {1'b0, p2_ff} + 64'h0000_4000_0000_0000;
      if (meta2_ff.axis) begin
         radius_in = arad2_ff;
      end else if (|ssum[63:32]) begin
         radius_in = 16'hFFFF;
      end else begin
         radius_in = ssum[31:16];
      end
      rad_s = zneg2_ff ? -$signed({1'b0, rmag2_ff}) : $signed({1'b0, rmag2_ff});
      deg_s = zneg2_ff ? -$signed({1'b0, psum[63:47]}) : $signed({1'b0, psum[63:47]});
      rad_c = rad_s;
      deg_c = deg_s;
      if (!meta2_ff.axis) begin
         if (rad_s > RAD_MAX) rad_c = RAD_MAX;
         else if (rad_s < RAD_MIN) rad_c = RAD_MIN;
         if (deg_s > DEG_MAX) deg_c = DEG_MAX;
         else if (deg_s < DEG_MIN) deg_c = DEG_MIN;
      end
   end

   // Advance through the three post stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid_i;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
      meta1_ff  <= meta_i;
      t1_ff     <= ux[31:0] * GAIN_Q32;
      hi1_ff    <= ux[63:32];
      av1_ff    <= zabs[32:0];
      zneg1_ff  <= z_i[ANGLE_WIDTH-1];
      arad1_ff  <= arad_in;

      meta2_ff  <= meta1_ff;
      h2_ff     <= hi1_ff * GAIN_Q32;
      thi2_ff   <= t1_ff[63:32];
      p2_ff     <= av1_ff * DEG_PER_RAD_Q24;
      rmag2_ff  <= rsum[33:17];
      zneg2_ff  <= zneg1_ff;
      arad2_ff  <= arad1_ff;

      radius_ff <= radius_in;
      rad_ff    <= rad_c[15:0];
      deg_ff    <= deg_c[15:0];
      loc_ff    <= meta2_ff.location;
   end

   assign rsp_valid     = valid3_ff;
   assign rsp_radius    = radius_ff;
   assign rsp_angle_rad = rad_ff;
   assign rsp_angle_deg = deg_ff;
   assign rsp_location  = loc_ff;

endmodule

// File: design/cartesian_to_polar_classify_core.sv
// Throughput: one word per clock cycle; busy stays low, the pipeline never stalls.
// The pipeline is one input register, the chain of CORDIC cells (one registered
// micro-rotation each) and three gain and rounding stages.
// Reset (synchronous, active high) clears every valid bit; words in flight are dropped.
`timescale 1ns / 1ps
module cartesian_to_polar_classify_core #(
   parameter int COORD_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   output logic               rsp_valid,
   output logic [15:0]        rsp_radius,
   output logic signed [15:0] rsp_angle_rad,
   output logic signed [15:0] rsp_angle_deg,
   output logic [3:0]         rsp_location
);
   import cpc_pkg::*;

   localparam int XYW = COORD_WIDTH + 19;
   localparam int LAT = CORDIC_STAGES + 4;

   localparam logic [3:0] LOC_ORIGIN = 4'd0;
   localparam logic [3:0] LOC_POS_X  = 4'd1;
   localparam logic [3:0] LOC_NEG_X  = 4'd2;
   localparam logic [3:0] LOC_POS_Y  = 4'd3;
   localparam logic [3:0] LOC_NEG_Y  = 4'd4;
   localparam logic [3:0] LOC_QI     = 4'd5;
   localparam logic [3:0] LOC_QII    = 4'd6;
   localparam logic [3:0] LOC_QIII   = 4'd7;
   localparam logic [3:0] LOC_QIV    = 4'd8;

   logic [31:0]                xw, yw;
   logic signed [COORD_WIDTH-1:0] xc, yc;
   logic signed [XYW-1:0]      xf, yf, ax, ay, xs, ys;
   logic                       x_zero, y_zero, x_neg, y_pos;
   cpc_meta_type               meta_in;
   logic signed [XYW-1:0]      cx_in, cy_in;
   logic signed [ANGLE_WIDTH-1:0] z_in;

   logic                          valid_s [0:CORDIC_STAGES];
   cpc_meta_type                  meta_s  [0:CORDIC_STAGES];
   logic signed [XYW-1:0]         cx_s    [0:CORDIC_STAGES];
   logic signed [XYW-1:0]         cy_s    [0:CORDIC_STAGES];
   logic signed [ANGLE_WIDTH-1:0] z_s     [0:CORDIC_STAGES];

   assign busy = 1'b0;

   // Take the low COORD_WIDTH bits of each coordinate, sign-extended
   always_comb begin
      xw = {16'd0, req_coord_x};
      yw = {16'd0, req_coord_y};
      xc = xw[COORD_WIDTH-1:0];
      yc = yw[COORD_WIDTH-1:0];
      xf = {{(XYW-COORD_WIDTH){xc[COORD_WIDTH-1]}}, xc};
      yf = {{(XYW-COORD_WIDTH){yc[COORD_WIDTH-1]}}, yc};
      ax = xf[XYW-1] ? -xf : xf;
      ay = yf[XYW-1] ? -yf : yf;
      xs = {xf[XYW-17:0], 16'd0};
      ys = {yf[XYW-17:0], 16'd0};
   end

   // Classify the point and pre-rotate the left half-plane by pi
   always_comb begin
      x_zero = (xc == '0);
      y_zero = (yc == '0);
      x_neg  = xc[COORD_WIDTH-1];
      y_pos  = !yc[COORD_WIDTH-1] && !y_zero;
      meta_in.axis = x_zero || y_zero;
      cx_in = '0;
      cy_in = '0;
      z_in  = '0;
      if (x_zero && y_zero) begin
         meta_in.location = LOC_ORIGIN;
      end else if (y_zero) begin
         meta_in.location = x_neg ? LOC_NEG_X : LOC_POS_X;
         cx_in = ax;
         z_in  = x_neg ? PI_Q30 : '0;
      end else if (x_zero) begin
         meta_in.location = y_pos ? LOC_POS_Y : LOC_NEG_Y;
         cx_in = ay;
         z_in  = y_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
      end else if (!x_neg) begin
         meta_in.location = y_pos ? LOC_QI : LOC_QIV;
         cx_in = xs;
         cy_in = ys;
      end else begin
         meta_in.location = y_pos ? LOC_QII : LOC_QIII;
         cx_in = -xs;
         cy_in = -ys;
         z_in  = y_pos ? PI_Q30 : -PI_Q30;
      end
   end

   // Register the classified word at the head of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s[0] <= 1'b0;
      end else begin
         valid_s[0] <= start && !busy;
      end
      meta_s[0] <= meta_in;
      cx_s[0]   <= cx_in;
      cy_s[0]   <= cy_in;
      z_s[0]    <= z_in;
   end

   // Chain of vectoring cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      cpc_cordic_cell #(
         .XY_WIDTH (XYW),
         .SHIFT    (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_s[i]),
         .meta_i  (meta_s[i]),
         .cx_i    (cx_s[i]),
         .cy_i    (cy_s[i]),
         .z_i     (z_s[i]),
         .valid_o (valid_s[i+1]),
         .meta_o  (meta_s[i+1]),
         .cx_o    (cx_s[i+1]),
         .cy_o    (cy_s[i+1]),
         .z_o     (z_s[i+1])
      );
   end

   // Gain correction and output formatting
   cpc_post #(
      .XY_WIDTH (XYW)
   ) u_post (
      .clock         (clock),
      .reset         (reset),
      .valid_i       (valid_s[CORDIC_STAGES]),
      .meta_i        (meta_s[CORDIC_STAGES]),
      .cx_i          (cx_s[CORDIC_STAGES]),
      .z_i           (z_s[CORDIC_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_radius    (rsp_radius),
      .rsp_angle_rad (rsp_angle_rad),
      .rsp_angle_deg (rsp_angle_deg),
      .rsp_location  (rsp_location)
   );

   // Every accepted word comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted word did not produce a result in time");

   // The origin gives zero radius and zero angles
   a_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_location == LOC_ORIGIN) |->
         (rsp_radius == 16'd0 && rsp_angle_rad == 16'sd0 && rsp_angle_deg == 16'sd0))
      else $error("origin result is not zero");

   // The negative x axis gives exactly +pi and +180 degrees
   a_neg_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_location == LOC_NEG_X) |->
         (rsp_angle_rad == 16'sd25736 && rsp_angle_deg == 16'sd23040))
      else $error("negative x axis angle is not +pi");

endmodule
